>>> rtl/core/esr_pkg.sv
package esr_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned SlotFw   = 8;
  localparam int unsigned NodeFw   = 6;
  localparam int unsigned StatusFw = 2;

  // Depths of the index-reduction tables (one entry per port code)
  localparam int unsigned SlotTblDepth = 2 ** SlotFw;
  localparam int unsigned NodeTblDepth = 2 ** NodeFw;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SWAP = 1'b1
  } op_e;

  typedef enum logic [StatusFw-1:0] {
    ST_LOADED    = 2'd0,
    ST_SWAPPED   = 2'd1,
    ST_SELF_LOOP = 2'd2,
    ST_EXISTS    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_EV,
    S_CHK_RD,
    S_CHK_EV,
    S_WR_A,
    S_WR_B,
    S_BIT_RD,
    S_BIT_WR,
    S_DONE
  } state_e;

  // Adjacency bit updates, in the order they are applied
  typedef enum logic [1:0] {
    BOP_CLR_OLD_A = 2'd0,
    BOP_CLR_OLD_B = 2'd1,
    BOP_SET_NEW_B = 2'd2,
    BOP_SET_NEW_A = 2'd3
  } bitop_e;

endpackage

>>> rtl/core/edge_switch_randomizer.sv
// Degree-preserving edge switcher.
// Input channel (in_valid_i / in_ready_o): one beat is a load of one edge
// into a slot, or a swap attempt on two slots with a direction bit.
// Output channel (out_valid_o / out_ready_i): exactly one result beat per
// input beat, in order: status plus the edges now held at slots a and b.
// Edges live in a one-write, two-read synchronous edge RAM; the adjacency
// bit matrix lives in a row RAM of NODES rows, updated read-modify-write.
// Items are handled one at a time. States run after accept:
//   load                      slot write, row RMW
//   swap rejected, self-loop  edge evaluation
//   swap rejected, existing   edge evaluation, adjacency check
//   swap done                 evaluation, check, two slot writes, four row RMW
// and then the result is registered as the block returns to idle.
// The row RMWs run in sequence on the single write port of the row RAM.
// After reset the row RAM is swept to zero, row by row, with in_ready_o
// low; the edge RAM is not cleared and a slot must be loaded before use.
// A stalled receiver holds the result in the output register; the block
// finishes the current item and then waits before it takes another.
module edge_switch_randomizer
  import esr_pkg::*;
#(
  parameter int unsigned NODES = 64,
  parameter int unsigned EDGES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [SlotFw-1:0]   edge_index_a_i,
  input  logic [SlotFw-1:0]   edge_index_b_i,
  input  logic [NodeFw-1:0]   node_u_i,
  input  logic [NodeFw-1:0]   node_v_i,
  input  logic                direction_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusFw-1:0] status_o,
  output logic [NodeFw-1:0]   edge_a_low_o,
  output logic [NodeFw-1:0]   edge_a_high_o,
  output logic [NodeFw-1:0]   edge_b_low_o,
  output logic [NodeFw-1:0]   edge_b_high_o
);

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned EW = $clog2(EDGES);

  // Port codes reduced modulo the graph size
  logic [NW-1:0] node_tbl [NodeTblDepth];
  logic [EW-1:0] slot_tbl [SlotTblDepth];

  for (genvar g = 0; g < NodeTblDepth; g++) begin : g_node_tbl
    assign node_tbl[g] = NW'(g % NODES);
  end

  for (genvar g = 0; g < SlotTblDepth; g++) begin : g_slot_tbl
    assign slot_tbl[g] = EW'(g % EDGES);
  end

  state_e  state_q, state_d;
  status_e status_q, status_d;
  bitop_e  bop_q, bop_d;
  logic    in_fire;
  logic    out_load;

  logic [EW-1:0] slot_a_q, slot_b_q;
  logic          dir_q;
  logic [NW-1:0] old_al_q, old_ah_q, old_bl_q, old_bh_q;
  logic [NW-1:0] new_al_q, new_ah_q, new_bl_q, new_bh_q;

  // Edge RAM: word is {low, high}
  logic [2*NW-1:0] edge_mem [EDGES];
  logic [2*NW-1:0] edge_rd_a_q, edge_rd_b_q;
  logic            edge_we;
  logic [EW-1:0]   edge_waddr;
  logic [2*NW-1:0] edge_wdata;

  logic [NW-1:0] in_u, in_v, ld_lo, ld_hi;
  logic [NW-1:0] rd_al, rd_ah, rd_bl, rd_bh, pair_x, pair_y;
  logic [NW-1:0] nal, nah, nbl, nbh;
  logic          self_loop;

  logic             adj_we;
  logic [NW-1:0]    adj_raddr_a;
  logic [NODES-1:0] adj_rd_a, adj_rd_b, adj_wdata;
  logic             adj_busy;
  logic             edge_exists;

  logic [NW-1:0] bop_row, bop_col;
  logic          bop_set;

  logic          out_valid_q;
  status_e       out_status_q;
  logic [NW-1:0] res_al, res_ah, res_bl, res_bh;
  logic [NodeFw-1:0] out_al_q, out_ah_q, out_bl_q, out_bh_q;

  assign in_ready_o = (state_q == S_IDLE) && !adj_busy;
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_u  = node_tbl[node_u_i];
  assign in_v  = node_tbl[node_v_i];
  assign ld_lo = (in_u < in_v) ? in_u : in_v;
  assign ld_hi = (in_u < in_v) ? in_v : in_u;

  // Pairing of the two fetched edges
  assign rd_al  = edge_rd_a_q[2*NW-1:NW];
  assign rd_ah  = edge_rd_a_q[NW-1:0];
  assign rd_bl  = edge_rd_b_q[2*NW-1:NW];
  assign rd_bh  = edge_rd_b_q[NW-1:0];
  assign pair_x = dir_q ? rd_bl : rd_bh;
  assign pair_y = dir_q ? rd_bh : rd_bl;
  assign nal    = (rd_al < pair_x) ? rd_al : pair_x;
  assign nah    = (rd_al < pair_x) ? pair_x : rd_al;
  assign nbl    = (rd_ah < pair_y) ? rd_ah : pair_y;
  assign nbh    = (rd_ah < pair_y) ? pair_y : rd_ah;
  assign self_loop = (nal == nah) || (nbl == nbh);

  assign edge_exists = adj_rd_a[new_ah_q] | adj_rd_b[new_bh_q];

  always_comb begin
    unique case (bop_q)
      BOP_CLR_OLD_A: begin
        bop_row = old_al_q;
        bop_col = old_ah_q;
        bop_set = 1'b0;
      end
      BOP_CLR_OLD_B: begin
        bop_row = old_bl_q;
        bop_col = old_bh_q;
        bop_set = 1'b0;
      end
      BOP_SET_NEW_B: begin
        bop_row = new_bl_q;
        bop_col = new_bh_q;
        bop_set = 1'b1;
      end
      default: begin
        bop_row = new_al_q;
        bop_col = new_ah_q;
        bop_set = 1'b1;
      end
    endcase
  end

  assign adj_raddr_a = (state_q == S_CHK_RD) ? new_al_q : bop_row;
  assign adj_we      = (state_q == S_BIT_WR);

  always_comb begin
    adj_wdata          = adj_rd_a;
    adj_wdata[bop_col] = bop_set;
  end

  esr_adj #(
    .NODES(NODES)
  ) u_adj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (adj_we),
    .waddr_i   (bop_row),
    .wdata_i   (adj_wdata),
    .raddr_a_i (adj_raddr_a),
    .raddr_b_i (new_bl_q),
    .rdata_a_o (adj_rd_a),
    .rdata_b_o (adj_rd_b),
    .busy_o    (adj_busy)
  );

  // Edge RAM port
  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = slot_a_q;
    edge_wdata = {new_al_q, new_ah_q};
    if (state_q == S_WR_A) begin
      edge_we = 1'b1;
    end else if (state_q == S_WR_B) begin
      edge_we    = 1'b1;
      edge_waddr = slot_b_q;
      edge_wdata = {new_bl_q, new_bh_q};
    end
  end

  // Reads are launched at the accepting edge straight from the ports
  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rd_a_q <= edge_mem[slot_tbl[edge_index_a_i]];
    edge_rd_b_q <= edge_mem[slot_tbl[edge_index_b_i]];
  end

  // Control
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    bop_d    = bop_q;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (op_e'(operation_i) == OP_LOAD) begin
            status_d = ST_LOADED;
            state_d  = S_WR_A;
          end else begin
            status_d = ST_SWAPPED;
            state_d  = S_EDGE_EV;
          end
        end
      end
      S_EDGE_EV: begin
        if (self_loop) begin
          status_d = ST_SELF_LOOP;
          state_d  = S_DONE;
        end else begin
          state_d = S_CHK_RD;
        end
      end
      S_CHK_RD: state_d = S_CHK_EV;
      S_CHK_EV: begin
        if (edge_exists) begin
          status_d = ST_EXISTS;
          state_d  = S_DONE;
        end else begin
          state_d = S_WR_A;
        end
      end
      S_WR_A: begin
        if (status_q == ST_LOADED) begin
          bop_d   = BOP_SET_NEW_A;
          state_d = S_BIT_RD;
        end else begin
          state_d = S_WR_B;
        end
      end
      S_WR_B: begin
        bop_d   = BOP_CLR_OLD_A;
        state_d = S_BIT_RD;
      end
      S_BIT_RD: state_d = S_BIT_WR;
      S_BIT_WR: begin
        if (bop_q == BOP_SET_NEW_A) begin
          state_d = S_DONE;
        end else begin
          bop_d   = bitop_e'(bop_q + 2'd1);
          state_d = S_BIT_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_LOADED;
      bop_q       <= BOP_CLR_OLD_A;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      bop_q    <= bop_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      slot_a_q <= slot_tbl[edge_index_a_i];
      slot_b_q <= slot_tbl[edge_index_b_i];
      dir_q    <= direction_i;
      new_al_q <= ld_lo;
      new_ah_q <= ld_hi;
    end else if (state_q == S_EDGE_EV) begin
      old_al_q <= rd_al;
      old_ah_q <= rd_ah;
      old_bl_q <= rd_bl;
      old_bh_q <= rd_bh;
      new_al_q <= nal;
      new_ah_q <= nah;
      new_bl_q <= nbl;
      new_bh_q <= nbh;
    end
  end

  // Slot contents after the item
  always_comb begin
    unique case (status_q)
      ST_LOADED: begin
        res_al = new_al_q;
        res_ah = new_ah_q;
        res_bl = '0;
        res_bh = '0;
      end
      ST_SWAPPED: begin
        // same slot twice: the second write wins
        res_al = (slot_a_q == slot_b_q) ? new_bl_q : new_al_q;
        res_ah = (slot_a_q == slot_b_q) ? new_bh_q : new_ah_q;
        res_bl = new_bl_q;
        res_bh = new_bh_q;
      end
      default: begin
        res_al = old_al_q;
        res_ah = old_ah_q;
        res_bl = old_bl_q;
        res_bh = old_bh_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_al_q     <= NodeFw'(res_al);
      out_ah_q     <= NodeFw'(res_ah);
      out_bl_q     <= NodeFw'(res_bl);
      out_bh_q     <= NodeFw'(res_bh);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign edge_a_low_o  = out_al_q;
  assign edge_a_high_o = out_ah_q;
  assign edge_b_low_o  = out_bl_q;
  assign edge_b_high_o = out_bh_q;

  a_one_item_at_a_time: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_fire |=> !in_ready_o
  ) else $error("second beat accepted while an item is in flight");

  a_reject_no_edge_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (status_q == ST_SELF_LOOP || status_q == ST_EXISTS) |-> !edge_we
  ) else $error("rejected swap wrote the edge RAM");

  a_clear_blocks_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni) adj_busy |-> !in_ready_o
  ) else $error("input taken during row clearing sweep");

  a_row_write_in_sequence: assert property (
    @(posedge clk_i) disable iff (!rst_ni) adj_we |-> $past(state_q == S_BIT_RD)
  ) else $error("row write without preceding row read");

endmodule

>>> rtl/core/esr_adj.sv
module esr_adj #(
  parameter int unsigned NODES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [$clog2(NODES)-1:0]   waddr_i,
  input  logic [NODES-1:0]           wdata_i,
  input  logic [$clog2(NODES)-1:0]   raddr_a_i,
  input  logic [$clog2(NODES)-1:0]   raddr_b_i,
  output logic [NODES-1:0]           rdata_a_o,
  output logic [NODES-1:0]           rdata_b_o,
  output logic                       busy_o
);

  localparam int unsigned NW = $clog2(NODES);

  logic [NODES-1:0] row_mem [NODES];

  logic          busy_q, busy_d;
  logic [NW-1:0] clr_cnt_q, clr_cnt_d;
  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  logic [NODES-1:0] mem_wdata;
  logic          clr_last;

  assign clr_last = (clr_cnt_q == NW'(NODES - 1));

  // Zeroing sweep after reset, one row per cycle
  always_comb begin
    busy_d    = busy_q;
    clr_cnt_d = clr_cnt_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + NW'(1);
      if (clr_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign mem_we    = busy_q | we_i;
  assign mem_waddr = busy_q ? clr_cnt_q : waddr_i;
  assign mem_wdata = busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    rdata_a_o <= row_mem[raddr_a_i];
    rdata_b_o <= row_mem[raddr_b_i];
  end

  assign busy_o = busy_q;

  a_no_write_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> !we_i
  ) else $error("row write during clearing sweep");

  a_clear_ends: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (busy_q && clr_last) |=> !busy_q
  ) else $error("clearing sweep did not end at last row");

  a_clear_once: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !busy_q |=> !busy_q
  ) else $error("clearing sweep restarted without reset");

endmodule

>>> tb/sv/edge_switch_randomizer_tb.sv
`timescale 1ns / 100ps

module edge_switch_randomizer_tb;
  import esr_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned RandomBeats = 1250;
  localparam int unsigned PressureAfter = 150;
  localparam int unsigned PressureHold = 500;

  typedef struct packed {
    op_e               op;
    logic [SlotFw-1:0] slot_a;
    logic [SlotFw-1:0] slot_b;
    logic [NodeFw-1:0] node_u;
    logic [NodeFw-1:0] node_v;
    logic              dir;
  } switch_req_t;

  typedef struct packed {
    status_e           status;
    logic [NodeFw-1:0] a_low;
    logic [NodeFw-1:0] a_high;
    logic [NodeFw-1:0] b_low;
    logic [NodeFw-1:0] b_high;
  } switch_res_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                operation_i;
  logic [SlotFw-1:0]   edge_index_a_i;
  logic [SlotFw-1:0]   edge_index_b_i;
  logic [NodeFw-1:0]   node_u_i;
  logic [NodeFw-1:0]   node_v_i;
  logic                direction_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [StatusFw-1:0] status_o;
  logic [NodeFw-1:0]   edge_a_low_o;
  logic [NodeFw-1:0]   edge_a_high_o;
  logic [NodeFw-1:0]   edge_b_low_o;
  logic [NodeFw-1:0]   edge_b_high_o;

  edge_switch_randomizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .edge_index_a_i(edge_index_a_i),
    .edge_index_b_i(edge_index_b_i),
    .node_u_i      (node_u_i),
    .node_v_i      (node_v_i),
    .direction_i   (direction_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .edge_a_low_o  (edge_a_low_o),
    .edge_a_high_o (edge_a_high_o),
    .edge_b_low_o  (edge_b_low_o),
    .edge_b_high_o (edge_b_high_o)
  );

  // shadow of the edge slots and the adjacency matrix
  logic [NodeFw-1:0]       slot_low   [SlotTblDepth];
  logic [NodeFw-1:0]       slot_high  [SlotTblDepth];
  logic [NodeTblDepth-1:0] adj_rows   [NodeTblDepth];

  switch_req_t switch_requests[$];
  switch_res_t predicted_edges[$];

  // generator side: which slots hold an edge, so swaps never read a blank slot
  bit          slot_filled [SlotTblDepth];
  int unsigned filled_slots[$];

  int unsigned mismatches = 0;
  int unsigned accepted_beats = 0;
  int unsigned quiet_cycles = 0;
  logic        in_took = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_hold = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  bit          pressure_done = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_span(input bit calm);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (calm || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 50);
  endfunction

  function automatic switch_res_t apply_switch(input switch_req_t r);
    switch_res_t res;
    logic [NodeFw-1:0] al, ah, bl, bh, x, y, nal, nah, nbl, nbh;
    if (r.op == OP_LOAD) begin
      nal = (r.node_u < r.node_v) ? r.node_u : r.node_v;
      nah = (r.node_u < r.node_v) ? r.node_v : r.node_u;
      slot_low[r.slot_a]  = nal;
      slot_high[r.slot_a] = nah;
      adj_rows[nal][nah]  = 1'b1;
      res.status = ST_LOADED;
      res.a_low  = nal;
      res.a_high = nah;
      res.b_low  = '0;
      res.b_high = '0;
      return res;
    end
    al = slot_low[r.slot_a];
    ah = slot_high[r.slot_a];
    bl = slot_low[r.slot_b];
    bh = slot_high[r.slot_b];
    x = r.dir ? bl : bh;
    y = r.dir ? bh : bl;
    nal = (al < x) ? al : x;
    nah = (al < x) ? x : al;
    nbl = (ah < y) ? ah : y;
    nbh = (ah < y) ? y : ah;
    if (nal == nah || nbl == nbh) begin
      res.status = ST_SELF_LOOP;
    end else if (adj_rows[nal][nah] || adj_rows[nbl][nbh]) begin
      res.status = ST_EXISTS;
    end else begin
      res.status = ST_SWAPPED;
      slot_low[r.slot_a]  = nal;
      slot_high[r.slot_a] = nah;
      // slot b written last: wins when both indices match
      slot_low[r.slot_b]  = nbl;
      slot_high[r.slot_b] = nbh;
      adj_rows[al][ah]    = 1'b0;
      adj_rows[bl][bh]    = 1'b0;
      adj_rows[nal][nah]  = 1'b1;
      adj_rows[nbl][nbh]  = 1'b1;
    end
    res.a_low  = slot_low[r.slot_a];
    res.a_high = slot_high[r.slot_a];
    res.b_low  = slot_low[r.slot_b];
    res.b_high = slot_high[r.slot_b];
    return res;
  endfunction

  task automatic add_load(input int unsigned slot, input int unsigned u, input int unsigned v);
    switch_req_t r;
    r.op     = OP_LOAD;
    r.slot_a = slot[SlotFw-1:0];
    r.slot_b = SlotFw'($urandom_range(0, SlotTblDepth - 1));
    r.node_u = u[NodeFw-1:0];
    r.node_v = v[NodeFw-1:0];
    r.dir    = 1'($urandom_range(0, 1));
    switch_requests = {switch_requests, r};
    if (!slot_filled[r.slot_a]) begin
      slot_filled[r.slot_a] = 1'b1;
      filled_slots = {filled_slots, 32'(r.slot_a)};
    end
  endtask

  task automatic add_swap(input int unsigned sa, input int unsigned sb, input bit dir);
    switch_req_t r;
    r.op     = OP_SWAP;
    r.slot_a = sa[SlotFw-1:0];
    r.slot_b = sb[SlotFw-1:0];
    r.node_u = NodeFw'($urandom_range(0, NodeTblDepth - 1));
    r.node_v = NodeFw'($urandom_range(0, NodeTblDepth - 1));
    r.dir    = dir;
    switch_requests = {switch_requests, r};
  endtask

  // driver: next beat goes out on a falling edge once the last one was taken and a random idle gap has run out
  always @(negedge clk_i) begin
    logic hold;
    switch_req_t cur;
    hold = in_valid_i && !in_took;
    if (!hold) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (switch_requests.size() != 0) begin
        cur = switch_requests.pop_front();
        operation_i    <= cur.op;
        edge_index_a_i <= cur.slot_a;
        edge_index_b_i <= cur.slot_b;
        node_u_i       <= cur.node_u;
        node_v_i       <= cur.node_v;
        direction_i    <= cur.dir;
        hold = 1'b1;
        if ($urandom_range(0, 79) == 0) send_calm = !send_calm;
        send_gap = idle_span(send_calm);
      end
    end
    in_valid_i <= hold;
  end

  // receiver: random back-pressure plus one long hold once traffic is flowing
  always @(negedge clk_i) begin
    logic rdy;
    if (!pressure_done && accepted_beats >= PressureAfter) begin
      pressure_done = 1'b1;
      recv_hold = PressureHold;
    end
    if (recv_hold != 0) begin
      recv_hold--;
      rdy = 1'b0;
    end else begin
      if ($urandom_range(0, 79) == 0) recv_calm = !recv_calm;
      recv_hold = idle_span(recv_calm);
      rdy = (recv_hold == 0);
      if (recv_hold != 0) recv_hold--;
    end
    out_ready_i <= rdy;
  end

  // monitor: check the outgoing beat first, then predict the incoming one
  always @(posedge clk_i) begin
    logic in_fire, out_fire;
    switch_req_t seen;
    switch_res_t want;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    in_took <= in_fire;
    if (out_fire) begin
      if (predicted_edges.size() == 0) begin
        $error("result beat with nothing expected: status %0d", status_o);
        mismatches++;
      end else begin
        want = predicted_edges.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (edge_a_low_o !== want.a_low) begin
          $error("edge_a_low: expected %0d, got %0d", want.a_low, edge_a_low_o);
          mismatches++;
        end
        if (edge_a_high_o !== want.a_high) begin
          $error("edge_a_high: expected %0d, got %0d", want.a_high, edge_a_high_o);
          mismatches++;
        end
        if (edge_b_low_o !== want.b_low) begin
          $error("edge_b_low: expected %0d, got %0d", want.b_low, edge_b_low_o);
          mismatches++;
        end
        if (edge_b_high_o !== want.b_high) begin
          $error("edge_b_high: expected %0d, got %0d", want.b_high, edge_b_high_o);
          mismatches++;
        end
      end
    end
    if (in_fire) begin
      seen.op     = op_e'(operation_i);
      seen.slot_a = edge_index_a_i;
      seen.slot_b = edge_index_b_i;
      seen.node_u = node_u_i;
      seen.node_v = node_v_i;
      seen.dir    = direction_i;
      predicted_edges = {predicted_edges, apply_switch(seen)};
      accepted_beats++;
    end
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned span, base, n, s, u, v, p, sa, sb;
    int unsigned round_slots[$];
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = 1'b0;
    edge_index_a_i = '0;
    edge_index_b_i = '0;
    node_u_i       = '0;
    node_v_i       = '0;
    direction_i    = 1'b0;
    out_ready_i    = 1'b0;
    foreach (adj_rows[i]) adj_rows[i] = '0;
    foreach (slot_low[i]) begin
      slot_low[i]  = '0;
      slot_high[i] = '0;
    end

    // directed: extreme slots and nodes, both directions, every status
    add_load(0, 63, 0);
    add_load(255, 1, 62);
    add_swap(0, 255, 1'b1);
    add_swap(0, 255, 1'b0);
    add_swap(0, 0, 1'b1);       // same slot: self-loop
    add_swap(0, 0, 1'b0);       // same slot: edge already present
    add_load(1, 7, 7);          // self-loop stored as given
    add_load(2, 0, 1);
    add_load(3, 2, 3);
    add_swap(2, 3, 1'b1);
    add_swap(2, 3, 1'b0);
    add_load(4, 63, 0);         // duplicate load
    add_swap(1, 2, 1'b1);
    add_load(5, 10, 11);
    add_swap(5, 4, 1'b1);
    add_swap(255, 4, 1'b0);
    add_load(0, 62, 63);        // overwrite leaves the old bit set
    add_swap(0, 255, 1'b1);
    add_swap(5, 2, 1'b0);
    add_load(6, 63, 63);
    add_swap(6, 0, 1'b0);
    add_swap(3, 3, 1'b1);

    // random rounds: load a small graph, then mostly swaps among its slots
    while (switch_requests.size() < RandomBeats) begin
      span = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : $urandom_range(9, 64);
      base = $urandom_range(0, NodeTblDepth - span);
      n = $urandom_range(2, 20);
      round_slots.delete();
      repeat (n) begin
        s = $urandom_range(0, SlotTblDepth - 1);
        u = base + $urandom_range(0, span - 1);
        v = base + $urandom_range(0, span - 1);
        if (u == v && $urandom_range(0, 7) != 0) v = base + ((v - base + 1) % span);
        add_load(s, u, v);
        round_slots = {round_slots, s};
      end
      repeat ($urandom_range(8, 50)) begin
        p = $urandom_range(0, 99);
        if (p < 8) begin
          s = $urandom_range(0, SlotTblDepth - 1);
          add_load(s, $urandom_range(0, NodeTblDepth - 1), $urandom_range(0, NodeTblDepth - 1));
        end else begin
          if (p < 16) begin
            sa = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
            sb = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
          end else begin
            sa = round_slots[$urandom_range(0, round_slots.size() - 1)];
            sb = round_slots[$urandom_range(0, round_slots.size() - 1)];
          end
          if (p < 20) sb = sa;
          add_swap(sa, sb, 1'($urandom_range(0, 1)));
        end
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (switch_requests.size() != 0 || in_valid_i) @(posedge clk_i);
    while (predicted_edges.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/esr_pkg.sv
rtl/core/esr_adj.sv
rtl/core/edge_switch_randomizer.sv
tb/sv/edge_switch_randomizer_tb.sv
